[rtl/tals_pkg.sv]
// Shared types, codes and helpers for the transform and line point sampler.
// No dependencies; imported by tals_div and transform_and_line_point_sampler.
package tals_pkg;

  // Iterative divider: quotient known to fit in DivQuotW bits.
  localparam int unsigned DivNumW  = 64;
  localparam int unsigned DivDenW  = 32;
  localparam int unsigned DivQuotW = 32;
  localparam int unsigned DivSteps = 32;

  typedef struct packed {
    logic                 start;
    logic [DivNumW-1:0]   num;
    logic [DivDenW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DivQuotW-1:0]  quot;
  } div_rsp_t;

  typedef enum logic [1:0] {
    FuncPoint  = 2'd0,
    FuncSphere = 2'd1,
    FuncLine   = 2'd2,
    FuncLineX  = 2'd3
  } func_e;

  localparam logic [2:0] CfgRowX   = 3'd0;
  localparam logic [2:0] CfgRowY   = 3'd1;
  localparam logic [2:0] CfgRowZ   = 3'd2;
  localparam logic [2:0] CfgScale  = 3'd3;
  localparam logic [2:0] CfgOffset = 3'd4;
  localparam logic [2:0] CfgSpace  = 3'd5;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
    logic signed [53:0] hi;
    logic signed [53:0] lo;
    hi = 54'sd2147483647;
    lo = -54'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Minor axes of a line, given its major axis.
  function automatic logic [1:0] minor_axis(input logic [1:0] maj, input logic k);
    case (maj)
      2'd0:    minor_axis = k ? 2'd2 : 2'd1;
      2'd1:    minor_axis = k ? 2'd2 : 2'd0;
      default: minor_axis = k ? 2'd1 : 2'd0;
    endcase
  endfunction

endpackage

[rtl/tals_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tals_pkg for the request and response structs.
module tals_div
  import tals_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q, done_q;
  logic [4:0]          cnt_q;
  logic [DivDenW-1:0]  rem_q, den_q;
  logic [DivQuotW-1:0] quo_q;
  logic [DivDenW:0]    trial;
  logic                ge;

  assign trial = {rem_q, quo_q[DivQuotW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // numerator is below den * 2^DivSteps, so the top half seeds the remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num[DivNumW-1:DivQuotW];
      quo_q <= req_i.num[DivQuotW-1:0];
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivQuotW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q;
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("div done while busy");

  property p_start_idle;
    @(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("div restarted while busy");

  property p_done_pulse;
    @(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("div done held");

endmodule

[rtl/transform_and_line_point_sampler.sv]
// Affine transform of points, spheres and lines, with line sampling.
// Each endpoint takes 12 shared multiplies; a sphere adds 2 multiplies for the radius, a line adds 3 divides
// and 4 multiplies; then one result beat per cycle while m_axis_tready_i is high, up to MAX_POINTS.
// Throughput: one item at a time, set by the shared 36x17 multiplier and the divider.
// Reset: async active low; config registers return to identity transform, spacing 1.0.
// Depends on tals_pkg and tals_div.
module transform_and_line_point_sampler
  import tals_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // ax, ay, az, bx, by, bz, radius_in (16 bits each)
  input  logic [111:0] s_axis_tdata_i,
  // func
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // px, py, pz, radius_out (32 bits each)
  output logic [127:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  // clipped
  output logic         m_axis_tuser_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  typedef enum logic [11:0] {
    StIdle = 12'b000000000001,
    StXMul = 12'b000000000010,
    StXAcc = 12'b000000000100,
    StRMul = 12'b000000001000,
    StRAcc = 12'b000000010000,
    StLen  = 12'b000000100000,
    StNDiv = 12'b000001000000,
    StSMul = 12'b000010000000,
    StSAcc = 12'b000100000000,
    StSDiv = 12'b001000000000,
    StPrep = 12'b010000000000,
    StEmit = 12'b100000000000
  } st_e;

  st_e state_q, state_d;

  logic [63:0] row_q [3];
  logic [47:0] scale_q, off_q;
  logic [31:0] spc_q;

  logic [1:0]  func_q;
  logic signed [15:0] a_q [3];
  logic signed [15:0] b_q [3];
  logic [15:0] rin_q;

  logic [1:0]  stp_q, axk_q, maj_q;
  logic        pt_q, mcnt_q;
  logic signed [35:0] acc_q;
  logic signed [52:0] prod_q;
  logic signed [31:0] pa_q [3];
  logic signed [31:0] pb_q [3];
  logic signed [32:0] dlt_q [3];
  logic [31:0] mag_q [3];
  logic [31:0] len_q;
  logic [63:0] dvd_q;
  logic signed [32:0] step_q [3];
  logic signed [39:0] cur_q [3];
  logic [CntW-1:0] np_q, cnt_q;
  logic        clip_q;
  logic signed [31:0] rad_q;

  logic [31:0] sp;
  logic signed [35:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [52:0] mul_p;
  logic signed [15:0] m_s, t_s, sc_s, of_s;
  logic signed [15:0] cin;
  logic signed [35:0] acc_nx;
  logic signed [53:0] xs;
  logic signed [31:0] coord;
  logic signed [32:0] d_c [3];
  logic [31:0] mag_c [3];
  logic [31:0] len_c;
  logic [1:0]  maj_c;
  logic [1:0]  mi;
  logic        in_acc, out_acc, out_last;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign sp = (spc_q == 32'd0) ? 32'd1 : spc_q;
  assign mi = minor_axis(maj_q, mcnt_q);

  assign m_s  = $signed(row_q[axk_q][16*stp_q +: 16]);
  assign t_s  = $signed(row_q[axk_q][63:48]);
  assign sc_s = $signed(scale_q[16*axk_q +: 16]);
  assign of_s = $signed(off_q[16*axk_q +: 16]);
  assign cin  = pt_q ? b_q[stp_q] : a_q[stp_q];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StXMul: begin
        if (stp_q == 2'd3) begin
          mul_a = acc_q;
          mul_b = 17'(sc_s);
        end else begin
          mul_a = 36'(cin);
          mul_b = 17'(m_s);
        end
      end
      StRMul: begin
        if (stp_q == 2'd0) begin
          mul_a = 36'($signed(row_q[0][15:0]));
          mul_b = 17'($signed(scale_q[15:0]));
        end else begin
          mul_a = prod_q[35:0];
          mul_b = {1'b0, rin_q};
        end
      end
      StSMul: begin
        mul_a = {4'b0, mag_q[mi]};
        mul_b = stp_q[0] ? {1'b0, sp[31:16]} : {1'b0, sp[15:0]};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign acc_nx = ((stp_q == 2'd0) ? (36'(t_s) <<< 8) : acc_q) + prod_q[35:0];
  assign xs     = (54'(prod_q) + (54'(of_s) <<< 20)) >>> 12;
  assign coord  = sat32(xs);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_c[k]   = 33'(pb_q[k]) - 33'(pa_q[k]);
      mag_c[k] = 32'(d_c[k][32] ? -d_c[k] : d_c[k]);
    end
    len_c = mag_c[0];
    maj_c = 2'd0;
    if (mag_c[1] > len_c) begin
      len_c = mag_c[1];
      maj_c = 2'd1;
    end
    if (mag_c[2] > len_c) begin
      len_c = mag_c[2];
      maj_c = 2'd2;
    end
  end

  always_comb begin
    dreq.start = (state_q == StLen) || (state_q == StSAcc && stp_q[0]);
    if (state_q == StLen) begin
      dreq.num = 64'(len_c);
      dreq.den = sp;
    end else begin
      dreq.num = dvd_q + (64'(prod_q[47:0]) << 16);
      dreq.den = len_q;
    end
  end

  tals_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign out_last = CntW'(cnt_q + 1'b1) == np_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = StXMul;
      StXMul: state_d = StXAcc;
      StXAcc: begin
        if (stp_q == 2'd3 && axk_q == 2'd2) begin
          if (pt_q) begin
            state_d = StLen;
          end else if (func_q == FuncPoint) begin
            state_d = StPrep;
          end else if (func_q == FuncSphere) begin
            state_d = StRMul;
          end else begin
            state_d = StXMul;
          end
        end else begin
          state_d = StXMul;
        end
      end
      StRMul: state_d = StRAcc;
      StRAcc: state_d = (stp_q == 2'd0) ? StRMul : StPrep;
      StLen:  state_d = StNDiv;
      StNDiv: if (drsp.done) state_d = (drsp.quot == '0) ? StIdle : StSMul;
      StSMul: state_d = StSAcc;
      StSAcc: state_d = stp_q[0] ? StSDiv : StSMul;
      StSDiv: if (drsp.done) state_d = mcnt_q ? StPrep : StSMul;
      StPrep: state_d = StEmit;
      StEmit: if (out_acc && out_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q[0] <= 64'h0000_0000_0000_1000;
      row_q[1] <= 64'h0000_0000_1000_0000;
      row_q[2] <= 64'h0000_1000_0000_0000;
      scale_q  <= 48'h0100_0100_0100;
      off_q    <= '0;
      spc_q    <= 32'h0001_0000;
      stp_q    <= '0;
      axk_q    <= '0;
      pt_q     <= 1'b0;
      mcnt_q   <= 1'b0;
      cnt_q    <= '0;
      np_q     <= '0;
      clip_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRowX:   row_q[0] <= cfg_wdata_i;
          CfgRowY:   row_q[1] <= cfg_wdata_i;
          CfgRowZ:   row_q[2] <= cfg_wdata_i;
          CfgScale:  scale_q  <= cfg_wdata_i[47:0];
          CfgOffset: off_q    <= cfg_wdata_i[47:0];
          CfgSpace:  spc_q    <= cfg_wdata_i[31:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            stp_q  <= '0;
            axk_q  <= '0;
            pt_q   <= 1'b0;
            np_q   <= CntW'(1);
            clip_q <= 1'b0;
          end
        end
        // stp_q wraps to zero after the scale step, ready for the sphere path
        StXAcc: begin
          stp_q <= stp_q + 2'd1;
          if (stp_q == 2'd3) begin
            if (axk_q == 2'd2) begin
              axk_q <= '0;
              pt_q  <= 1'b1;
            end else begin
              axk_q <= axk_q + 2'd1;
            end
          end
        end
        StRAcc: stp_q <= stp_q + 2'd1;
        StNDiv: begin
          if (drsp.done) begin
            stp_q  <= '0;
            mcnt_q <= 1'b0;
            if (drsp.quot > 32'(MAX_POINTS)) begin
              np_q   <= CntW'(MAX_POINTS);
              clip_q <= 1'b1;
            end else begin
              np_q <= drsp.quot[CntW-1:0];
            end
          end
        end
        StSAcc: stp_q <= stp_q + 2'd1;
        StSDiv: begin
          if (drsp.done) begin
            mcnt_q <= 1'b1;
            stp_q  <= '0;
          end
        end
        StPrep: cnt_q <= '0;
        StEmit: if (out_acc) cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          func_q <= s_axis_tuser_i;
          for (int k = 0; k < 3; k++) begin
            a_q[k] <= $signed(s_axis_tdata_i[16*k +: 16]);
            b_q[k] <= $signed(s_axis_tdata_i[48+16*k +: 16]);
          end
          rin_q <= s_axis_tdata_i[111:96];
          rad_q <= '0;
        end
      end
      StXMul, StRMul, StSMul: prod_q <= mul_p;
      StXAcc: begin
        if (stp_q == 2'd3) begin
          if (pt_q) pb_q[axk_q] <= coord;
          else      pa_q[axk_q] <= coord;
        end else begin
          acc_q <= acc_nx;
        end
      end
      StRAcc: if (stp_q != 2'd0) rad_q <= sat32(54'(prod_q) >>> 12);
      StLen: begin
        for (int k = 0; k < 3; k++) begin
          dlt_q[k] <= d_c[k];
          mag_q[k] <= mag_c[k];
        end
        len_q <= len_c;
        maj_q <= maj_c;
      end
      StNDiv: begin
        if (drsp.done) begin
          step_q[maj_q] <= dlt_q[maj_q][32] ? -33'(sp) : 33'(sp);
        end
      end
      StSAcc: if (!stp_q[0]) dvd_q <= 64'(prod_q[47:0]);
      StSDiv: begin
        if (drsp.done) begin
          step_q[mi] <= dlt_q[mi][32] ? -33'(drsp.quot) : 33'(drsp.quot);
        end
      end
      StPrep: for (int k = 0; k < 3; k++) cur_q[k] <= 40'(pa_q[k]);
      StEmit: begin
        if (out_acc) begin
          for (int k = 0; k < 3; k++) cur_q[k] <= cur_q[k] + 40'(step_q[k]);
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StEmit);
  assign m_axis_tdata_o  = {rad_q, sat32(54'(cur_q[2])), sat32(54'(cur_q[1])),
                            sat32(54'(cur_q[0]))};
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tuser_o  = clip_q;

  property p_one_side;
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid_o |-> !s_axis_tready_o;
  endproperty
  a_one_side: assert property (p_one_side) else $error("input and output both open");

  property p_div_done_state;
    @(posedge clk_i) disable iff (!rst_ni)
      drsp.done |-> (state_q == StNDiv || state_q == StSDiv);
  endproperty
  a_div_done_state: assert property (p_div_done_state) else $error("stray divide result");

  property p_clip_full;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && m_axis_tuser_o) |-> (np_q == CntW'(MAX_POINTS));
  endproperty
  a_clip_full: assert property (p_clip_full) else $error("clipped run not full");

  property p_cnt_range;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == StEmit) |-> (cnt_q < np_q);
  endproperty
  a_cnt_range: assert property (p_cnt_range) else $error("beat count past run");

endmodule

[verif/transform_and_line_point_sampler_tb.sv]
// Self-checking bench for transform_and_line_point_sampler: points, spheres and sampled lines.
// Uses tals_pkg codes; a bit-accurate in-bench predictor queues expected output beats.
module transform_and_line_point_sampler_tb;
  import tals_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPts = 64;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 300;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] rad;
    logic        last;
    logic        clip;
  } point_beat_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [111:0] s_axis_tdata_i;
  logic [1:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [127:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic         m_axis_tuser_o;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [63:0]  cfg_wdata_i;

  transform_and_line_point_sampler #(.MAX_POINTS(MaxPts)) u_dut (.*);

  // shadow copy of the register file
  logic [63:0] row_x, row_y, row_z;
  logic [47:0] scale_reg, offset_reg;
  logic [31:0] spacing_reg;

  point_beat_t pending_beats[$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  bit          hold_req;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    m_axis_tready_i = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(99) < 20) begin
        stall_left = ($urandom_range(99) < 90) ? $urandom_range(2) : $urandom_range(40, 10);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin
    point_beat_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected output beat %h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        e = pending_beats.pop_front();
        if (m_axis_tdata_o[31:0] !== e.px) begin
          $error("px exp %h got %h", e.px, m_axis_tdata_o[31:0]); fail_cnt++;
        end
        if (m_axis_tdata_o[63:32] !== e.py) begin
          $error("py exp %h got %h", e.py, m_axis_tdata_o[63:32]); fail_cnt++;
        end
        if (m_axis_tdata_o[95:64] !== e.pz) begin
          $error("pz exp %h got %h", e.pz, m_axis_tdata_o[95:64]); fail_cnt++;
        end
        if (m_axis_tdata_o[127:96] !== e.rad) begin
          $error("radius_out exp %h got %h", e.rad, m_axis_tdata_o[127:96]); fail_cnt++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last exp %b got %b", e.last, m_axis_tlast_o); fail_cnt++;
        end
        if (m_axis_tuser_o !== e.clip) begin
          $error("clipped exp %b got %b", e.clip, m_axis_tuser_o); fail_cnt++;
        end
      end
    end
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint xform_axis(logic [63:0] row, int axis, longint x, longint y,
                                        longint z);
    longint acc, s;
    acc = sx16(row[15:0]) * x + sx16(row[31:16]) * y + sx16(row[47:32]) * z
        + sx16(row[63:48]) * 256;
    s = sx16(scale_reg[16*axis +: 16]) * acc + sx16(offset_reg[16*axis +: 16]) * 1048576;
    return clamp32(s >>> 12);
  endfunction

  task automatic xform_point(input logic [15:0] v[3], output longint r[3]);
    r[0] = xform_axis(row_x, 0, sx16(v[0]), sx16(v[1]), sx16(v[2]));
    r[1] = xform_axis(row_y, 1, sx16(v[0]), sx16(v[1]), sx16(v[2]));
    r[2] = xform_axis(row_z, 2, sx16(v[0]), sx16(v[1]), sx16(v[2]));
  endtask

  // expected beats of one primitive
  task automatic sample_primitive(input func_e kind, input logic [15:0] a[3],
                                  input logic [15:0] b[3], input logic [15:0] radius);
    longint pa[3], pb[3], d[3], stp[3];
    longint unsigned mag[3], len, sp, np, q;
    int axis;
    bit clip;
    point_beat_t e;
    xform_point(a, pa);
    if (kind == FuncPoint || kind == FuncSphere) begin
      e.px = pa[0][31:0]; e.py = pa[1][31:0]; e.pz = pa[2][31:0];
      e.rad = '0;
      if (kind == FuncSphere)
        e.rad = 32'(clamp32((sx16(row_x[15:0]) * sx16(scale_reg[15:0])
                             * longint'(radius)) >>> 12));
      e.last = 1'b1; e.clip = 1'b0;
      pending_beats = {pending_beats, e};
      return;
    end
    xform_point(b, pb);
    for (int i = 0; i < 3; i++) begin
      d[i] = pb[i] - pa[i];
      mag[i] = (d[i] < 0) ? -d[i] : d[i];
    end
    len = mag[0]; axis = 0;
    if (mag[1] > len) begin len = mag[1]; axis = 1; end
    if (mag[2] > len) begin len = mag[2]; axis = 2; end
    sp = (spacing_reg == 32'd0) ? 64'd1 : 64'(spacing_reg);
    np = len / sp;
    if (np == 0) return;
    clip = 1'b0;
    if (np > MaxPts) begin np = 64'(MaxPts); clip = 1'b1; end
    for (int i = 0; i < 3; i++) begin
      if (i == axis) begin
        stp[i] = (pb[i] > pa[i]) ? longint'(sp) : -longint'(sp);
      end else begin
        q = (mag[i] * sp) / len;
        stp[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    for (int j = 0; j < int'(np); j++) begin
      e.px = 32'(clamp32(pa[0] + j * stp[0]));
      e.py = 32'(clamp32(pa[1] + j * stp[1]));
      e.pz = 32'(clamp32(pa[2] + j * stp[2]));
      e.rad = '0;
      e.last = (j == int'(np) - 1);
      e.clip = clip;
      pending_beats = {pending_beats, e};
    end
  endtask

  task automatic send_primitive(input func_e kind, input logic [15:0] a[3],
                                input logic [15:0] b[3], input logic [15:0] radius,
                                input bit no_gap = 0);
    int unsigned gap;
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {radius, b[2], b[1], b[0], a[2], a[1], a[0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sample_primitive(kind, a, b, radius);
    gap = 0;
    if (!no_gap) begin
      case ($urandom_range(19))
        0:             gap = $urandom_range(40, 10);
        1, 2, 3, 4, 5: gap = $urandom_range(3, 1);
        default:       gap = 0;
      endcase
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
    end else begin
      // the following call raises valid again; the block is busy by then
      s_axis_tvalid_i <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0) @(posedge clk_i);
    // lines that yield nothing can still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgRowX:   row_x = val;
      CfgRowY:   row_y = val;
      CfgRowZ:   row_z = val;
      CfgScale:  scale_reg = val[47:0];
      CfgOffset: offset_reg = val[47:0];
      CfgSpace:  spacing_reg = val[31:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [63:0] rx, ry, rz, input logic [47:0] sc, off,
                           input logic [31:0] sp);
    wait_idle();
    write_reg(CfgRowX, rx);
    write_reg(CfgRowY, ry);
    write_reg(CfgRowZ, rz);
    write_reg(CfgScale, sc);
    write_reg(CfgOffset, off);
    write_reg(CfgSpace, sp);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int unsigned n, input bit no_gap = 0);
    logic [15:0] a[3], b[3];
    func_e kind;
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_coord();
        b[i] = 16'($urandom);
      end
      r = $urandom_range(9);
      kind = (r < 2) ? FuncPoint : (r < 4) ? FuncSphere : (r < 9) ? FuncLine : FuncLineX;
      // mostly short lines so point counts stay moderate
      if (kind inside {FuncLine, FuncLineX} && $urandom_range(3) != 0)
        for (int i = 0; i < 3; i++) b[i] = a[i] + 16'($urandom_range(2047)) - 16'd1024;
      send_primitive(kind, a, b, 16'($urandom), no_gap);
    end
  endtask

  task automatic test_directed();
    logic [15:0] a[3], b[3];
    a = '{16'h7fff, 16'h8000, 16'h0000};
    b = '{16'h0000, 16'h0000, 16'h0000};
    send_primitive(FuncPoint, a, b, 16'h0000);
    a = '{16'h8000, 16'h7fff, 16'hffff};
    send_primitive(FuncPoint, a, b, 16'hffff);
    send_primitive(FuncSphere, a, b, 16'hffff);
    send_primitive(FuncSphere, a, b, 16'h0000);
    a = '{16'h0100, 16'h0100, 16'h0100};
    send_primitive(FuncSphere, a, b, 16'h0180);
    // zero length line: nothing out
    b = a;
    send_primitive(FuncLine, a, b, 16'h0000);
    // shorter than one spacing
    b = '{16'h0180, 16'h0100, 16'h0100};
    send_primitive(FuncLine, a, b, 16'h0000);
    // x/y tie goes to x
    b = '{16'h0500, 16'hfd00, 16'h0100};
    send_primitive(FuncLine, a, b, 16'h0000);
    b = '{16'h0100, 16'h0800, 16'hfe00};
    send_primitive(FuncLine, a, b, 16'h0000);
    b = '{16'h0000, 16'h0000, 16'hf000};
    send_primitive(FuncLineX, a, b, 16'h0000);
    // full-scale line: clipped
    a = '{16'h8000, 16'h8000, 16'h8000};
    b = '{16'h7fff, 16'h7fff, 16'h7fff};
    send_primitive(FuncLine, a, b, 16'h1234);
    send_primitive(FuncLineX, b, a, 16'h0000);
    a = '{16'h8000, 16'h0000, 16'h7fff};
    b = '{16'h8000 + 16'd16384, 16'h0000, 16'h7fff};
    send_primitive(FuncLine, a, b, 16'h0000);
  endtask

  task automatic test_config_extremes();
    logic [15:0] a[3], b[3];
    // saturating everything
    write_all({4{16'h7fff}}, {4{16'h8000}}, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
              {3{16'h7fff}}, {3{16'h8000}}, 32'hffffffff);
    send_random(10);
    // zero spacing acts as the smallest step
    write_all(64'h1000, 64'h1000 << 16, 64'h1000 << 32, 48'h010001000100, 48'h0, 32'h0);
    a = '{16'h0000, 16'h0000, 16'h0000};
    b = '{16'h0000, 16'h0001, 16'h0000};
    send_primitive(FuncLine, a, b, 16'h0000);
    send_random(6);
    write_all(64'h0, 64'h0, 64'h0, 48'h0, 48'hffffffffffff, 32'h1);
    send_random(6);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      logic [63:0] r[3];
      for (int i = 0; i < 3; i++) begin
        r[i] = {$urandom, $urandom};
        if (ph < 3)
          r[i] = {16'($urandom_range(8191)) - 16'd4096, 16'($urandom_range(8191)) - 16'd4096,
                  16'($urandom_range(8191)) - 16'd4096, 16'($urandom_range(8191)) - 16'd4096};
      end
      write_all(r[0], r[1], r[2],
                (ph < 3) ? {3{16'($urandom_range(511)) - 16'd256}} : 48'({$urandom, $urandom}),
                48'({$urandom, $urandom}),
                (ph < 4) ? 32'($urandom_range(32'h40000, 32'h4000)) : $urandom);
      send_random(25);
    end
  endtask

  task automatic test_backpressure();
    write_all(64'h1000, 64'h1000 << 16, 64'h1000 << 32, 48'h010001000100, 48'h0, 32'h8000);
    hold_req = 1'b1;
    send_random(15, 1);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgRowX;
    cfg_wdata_i = '0;
    fail_cnt = 0;
    cycle_cnt = 0;
    hold_req = 1'b0;
    row_x = 64'h1000;
    row_y = 64'h1000 << 16;
    row_z = 64'h1000 << 32;
    scale_reg = 48'h010001000100;
    offset_reg = '0;
    spacing_reg = 32'h10000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_random_settings();
    test_backpressure();
    send_random(20);

    wait_idle();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tals_pkg.sv
rtl/tals_div.sv
rtl/transform_and_line_point_sampler.sv
verif/transform_and_line_point_sampler_tb.sv
